>>> src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define RCPC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define RCPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/rcpc_pkg.sv
// Package for the rod cutting block: sizes, codes, command and status types.
package rcpc_pkg;

	localparam int MAX_LEN = 16;
	localparam int LEN_W = $clog2(MAX_LEN + 1);
	localparam int PADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

	localparam int CFG_W = 5;
	localparam int PRICE_W = 16;
	localparam int PROFIT_W = 20;
	localparam int CUTF_W = 5;

	localparam logic [CFG_W-1:0] ROD_LEN_RESET = CFG_W'(8);
	localparam logic [PROFIT_W-1:0] PROFIT_MAX = {PROFIT_W{1'b1}};

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_INIT,
		ST_ISSUE,
		ST_DRAIN,
		ST_WRITE,
		ST_WREAD,
		ST_WCALC
	} state_t;

	typedef struct packed {
		logic load;
		logic init;
		logic issue;
		logic write_n;
		logic walk_rd;
		logic walk_emit;
	} cmd_t;

	typedef struct packed {
		logic load_done;
		logic issue_last;
		logic n_last;
		logic walk_last;
		logic out_free;
	} status_t;

	// zero reads as one, anything above the maximum saturates
	function automatic logic [LEN_W-1:0] eff_len(input logic [CFG_W-1:0] r);
		logic [LEN_W-1:0] l;
		if (r == '0) begin
			l = LEN_W'(1);
		end else if (int'(r) > MAX_LEN) begin
			l = LEN_W'(MAX_LEN);
		end else begin
			l = LEN_W'(r);
		end
		return l;
	endfunction

endpackage

>>> src/rcpc_price_if.sv
// Price channel: valid/ready handshake carrying one price word.
interface rcpc_price_if;
	logic valid;
	logic ready;
	logic [rcpc_pkg::PRICE_W-1:0] price_value;

	modport source (output valid, output price_value, input ready);
	modport sink (input valid, input price_value, output ready);
endinterface

>>> src/rcpc_cut_if.sv
// Cut channel: valid/ready handshake carrying one piece of the best cutting.
interface rcpc_cut_if;
	logic valid;
	logic ready;
	logic [rcpc_pkg::CUTF_W-1:0] cut_length;
	logic [rcpc_pkg::PROFIT_W-1:0] total_profit;
	logic last_cut;

	modport source (output valid, output cut_length, output total_profit, output last_cut,
		input ready);
	modport sink (input valid, input cut_length, input total_profit, input last_cut,
		output ready);
endinterface

>>> src/rcpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rcpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic                 re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]     rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

>>> src/rcpc_datapath.sv
// Datapath: price/profit/cut stores, DP compare-add, walk-back and output register.
module rcpc_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rcpc_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic [rcpc_pkg::PRICE_W-1:0]   price_value,
	input  rcpc_pkg::cmd_t                 cmd,
	output rcpc_pkg::status_t              status,
	rcpc_cut_if.source                     cut
);
	logic [rcpc_pkg::CFG_W-1:0]    rod_len_q;
	logic [rcpc_pkg::LEN_W-1:0]    load_cnt_q;
	logic [rcpc_pkg::LEN_W-1:0]    len_eff;
	logic [rcpc_pkg::LEN_W-1:0]    n_q;
	logic [rcpc_pkg::LEN_W-1:0]    i_q;
	logic [rcpc_pkg::LEN_W-1:0]    i_s1;
	logic                          vld_s1;
	logic [rcpc_pkg::PROFIT_W-1:0] best_q;
	logic [rcpc_pkg::LEN_W-1:0]    bcut_q;
	logic [rcpc_pkg::PROFIT_W-1:0] profit_q;
	logic [rcpc_pkg::LEN_W-1:0]    remain_q;
	logic                          out_vld_q;
	logic [rcpc_pkg::CUTF_W-1:0]   out_len_q;
	logic [rcpc_pkg::PROFIT_W-1:0] out_profit_q;
	logic                          out_last_q;

	logic [rcpc_pkg::PRICE_W-1:0]  price_rd;
	logic [rcpc_pkg::PROFIT_W-1:0] profit_rd;
	logic [rcpc_pkg::LEN_W-1:0]    cut_rd;
	logic [rcpc_pkg::LEN_W-1:0]    i_m1;
	logic [rcpc_pkg::PROFIT_W:0]   cand_sum;
	logic [rcpc_pkg::PROFIT_W-1:0] cand;
	logic [rcpc_pkg::LEN_W-1:0]    c_fix;
	logic [rcpc_pkg::LEN_W-1:0]    rem_next;
	logic                          prof_we;
	logic [rcpc_pkg::LEN_W-1:0]    prof_waddr;
	logic [rcpc_pkg::PROFIT_W-1:0] prof_wdata;

	assign len_eff = rcpc_pkg::eff_len(rod_len_q);
	assign i_m1 = i_q - rcpc_pkg::LEN_W'(1);

	// stores
	rcpc_ram #(.WIDTH(rcpc_pkg::PRICE_W), .DEPTH(rcpc_pkg::MAX_LEN)) u_price_ram (
		.clk   (clk),
		.we    (cmd.load),
		.waddr (load_cnt_q[rcpc_pkg::PADDR_W-1:0]),
		.wdata (price_value),
		.re    (cmd.issue),
		.raddr (i_m1[rcpc_pkg::PADDR_W-1:0]),
		.rdata (price_rd)
	);

	assign prof_we = cmd.init | cmd.write_n;
	assign prof_waddr = cmd.init ? '0 : n_q;
	assign prof_wdata = cmd.init ? '0 : best_q;

	rcpc_ram #(.WIDTH(rcpc_pkg::PROFIT_W), .DEPTH(rcpc_pkg::MAX_LEN + 1)) u_profit_ram (
		.clk   (clk),
		.we    (prof_we),
		.waddr (prof_waddr),
		.wdata (prof_wdata),
		.re    (cmd.issue),
		.raddr (n_q - i_q),
		.rdata (profit_rd)
	);

	rcpc_ram #(.WIDTH(rcpc_pkg::LEN_W), .DEPTH(rcpc_pkg::MAX_LEN + 1)) u_cut_ram (
		.clk   (clk),
		.we    (cmd.write_n),
		.waddr (n_q),
		.wdata (bcut_q),
		.re    (cmd.walk_rd),
		.raddr (remain_q),
		.rdata (cut_rd)
	);

	// candidate profit, saturated
	always_comb begin
		cand_sum = (rcpc_pkg::PROFIT_W + 1)'(price_rd) + (rcpc_pkg::PROFIT_W + 1)'(profit_rd);
		if (cand_sum > (rcpc_pkg::PROFIT_W + 1)'(rcpc_pkg::PROFIT_MAX)) begin
			cand = rcpc_pkg::PROFIT_MAX;
		end else begin
			cand = cand_sum[rcpc_pkg::PROFIT_W-1:0];
		end
	end

	// stored cut repaired so the walk always shrinks
	always_comb begin
		if (cut_rd == '0 || cut_rd > remain_q) begin
			c_fix = remain_q;
		end else begin
			c_fix = cut_rd;
		end
		rem_next = remain_q - c_fix;
	end

	always_comb begin
		status.load_done  = ({1'b0, load_cnt_q} + (rcpc_pkg::LEN_W + 1)'(1)) >= {1'b0, len_eff};
		status.issue_last = (i_q == n_q);
		status.n_last     = (n_q == len_eff);
		status.walk_last  = (rem_next == '0);
		status.out_free   = !out_vld_q || cut.ready;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rod_len_q  <= rcpc_pkg::ROD_LEN_RESET;
			load_cnt_q <= '0;
			vld_s1     <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				rod_len_q  <= cfg_wdata;
				load_cnt_q <= '0;
			end else if (cmd.load) begin
				load_cnt_q <= status.load_done ? '0 : load_cnt_q + rcpc_pkg::LEN_W'(1);
			end
			vld_s1 <= cmd.issue;
			if (cmd.walk_emit) begin
				out_vld_q <= 1'b1;
			end else if (cut.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			i_s1 <= i_q;
		end
		if (cmd.init) begin
			n_q    <= rcpc_pkg::LEN_W'(1);
			i_q    <= rcpc_pkg::LEN_W'(1);
			best_q <= '0;
			bcut_q <= rcpc_pkg::LEN_W'(1);
		end else if (cmd.write_n) begin
			n_q    <= n_q + rcpc_pkg::LEN_W'(1);
			i_q    <= rcpc_pkg::LEN_W'(1);
			best_q <= '0;
			bcut_q <= n_q + rcpc_pkg::LEN_W'(1);
			if (status.n_last) begin
				profit_q <= best_q;
				remain_q <= len_eff;
			end
		end else begin
			if (cmd.issue) begin
				i_q <= i_q + rcpc_pkg::LEN_W'(1);
			end
			// first strict improvement wins
			if (vld_s1 && cand > best_q) begin
				best_q <= cand;
				bcut_q <= i_s1;
			end
		end
		if (cmd.walk_emit) begin
			out_len_q    <= rcpc_pkg::CUTF_W'(c_fix);
			out_profit_q <= profit_q;
			out_last_q   <= status.walk_last;
			remain_q     <= rem_next;
		end
	end

	assign cut.valid        = out_vld_q;
	assign cut.cut_length   = out_len_q;
	assign cut.total_profit = out_profit_q;
	assign cut.last_cut     = out_last_q;
endmodule

>>> src/rcpc_ctrl.sv
// Controller: sequences loading, the DP sweep and the walk-back.
module rcpc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              price_valid,
	output logic              price_ready,
	input  rcpc_pkg::status_t status,
	output rcpc_pkg::cmd_t    cmd
);
	rcpc_pkg::state_t state_q;
	rcpc_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rcpc_pkg::ST_LOAD;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			rcpc_pkg::ST_LOAD: begin
				if (price_valid && status.load_done) begin
					state_nxt = rcpc_pkg::ST_INIT;
				end
			end
			rcpc_pkg::ST_INIT: begin
				state_nxt = rcpc_pkg::ST_ISSUE;
			end
			rcpc_pkg::ST_ISSUE: begin
				if (status.issue_last) begin
					state_nxt = rcpc_pkg::ST_DRAIN;
				end
			end
			rcpc_pkg::ST_DRAIN: begin
				state_nxt = rcpc_pkg::ST_WRITE;
			end
			rcpc_pkg::ST_WRITE: begin
				state_nxt = status.n_last ? rcpc_pkg::ST_WREAD : rcpc_pkg::ST_ISSUE;
			end
			rcpc_pkg::ST_WREAD: begin
				state_nxt = rcpc_pkg::ST_WCALC;
			end
			rcpc_pkg::ST_WCALC: begin
				if (status.out_free) begin
					state_nxt = status.walk_last ? rcpc_pkg::ST_LOAD : rcpc_pkg::ST_WREAD;
				end
			end
			default: begin
				state_nxt = rcpc_pkg::ST_LOAD;
			end
		endcase
	end

	always_comb begin
		price_ready = 1'b0;
		cmd = '0;
		case (state_q)
			rcpc_pkg::ST_LOAD: begin
				price_ready = 1'b1;
				cmd.load = price_valid;
			end
			rcpc_pkg::ST_INIT: begin
				cmd.init = 1'b1;
			end
			rcpc_pkg::ST_ISSUE: begin
				cmd.issue = 1'b1;
			end
			rcpc_pkg::ST_DRAIN: begin
			end
			rcpc_pkg::ST_WRITE: begin
				cmd.write_n = 1'b1;
			end
			rcpc_pkg::ST_WREAD: begin
				cmd.walk_rd = 1'b1;
			end
			rcpc_pkg::ST_WCALC: begin
				cmd.walk_emit = status.out_free;
			end
			default: begin
			end
		endcase
	end
endmodule

>>> src/rod_cutting_profit_and_cuts_top.sv
// Top level of the rod cutting block: controller, datapath and channel hookup.
// Loading: one price word per cycle; the word that completes a load of L prices
// starts the solve. Solve: an init step, then for each length n an issue run over
// cuts 1 to n, a drain and a write, one compare-add per cycle through the
// registered-read price and profit stores. Walk-back: each cut word is a cut store
// read, then the output register, which waits while the previous word is stalled.
// arst_n clears the controller, the load count, the valid flags and sets rod length 8.
module rod_cutting_profit_and_cuts_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [rcpc_pkg::CFG_W-1:0] cfg_wdata,
	rcpc_price_if.sink                 price,
	rcpc_cut_if.source                 cut
);
	rcpc_pkg::cmd_t    cmd;
	rcpc_pkg::status_t status;
	logic              price_ready;

	// The controller owns the sequence; it sees only status flags and the price
	// valid, the datapath only ever sees one-hot-ish command strobes.
	rcpc_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.price_valid (price.valid),
		.price_ready (price_ready),
		.status      (status),
		.cmd         (cmd)
	);

	// Stores, compare-add, walk-back and the cut word register. The cut word
	// register lets the block take the next load's prices while the final
	// piece of the previous cutting still waits downstream.
	rcpc_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.price_value (price.price_value),
		.cmd         (cmd),
		.status      (status),
		.cut         (cut)
	);

	// price words are only taken while loading
	assign price.ready = price_ready;
endmodule

>>> src/rcpc_checker.sv
// Port-level checker for the rod cutting block, bound to the top level.
`include "assert_macros.svh"

module rcpc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cut_valid,
	input logic                          cut_ready,
	input logic [rcpc_pkg::CUTF_W-1:0]   cut_length,
	input logic [rcpc_pkg::PROFIT_W-1:0] total_profit,
	input logic                          last_cut
);
	logic                          mid_q;
	logic [rcpc_pkg::PROFIT_W-1:0] profit_q;
	logic [rcpc_pkg::LEN_W:0]      sum_q;
	logic                          acc;

	assign acc = cut_valid && cut_ready;

	// track the cutting currently being delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_q    <= 1'b0;
			profit_q <= '0;
			sum_q    <= '0;
		end else if (acc) begin
			mid_q    <= !last_cut;
			profit_q <= total_profit;
			sum_q    <= last_cut ? '0 : sum_q + (rcpc_pkg::LEN_W + 1)'(cut_length);
		end
	end

	`RCPC_ASSERT_NEXT(a_cut_hold, clk, arst_n, cut_valid && !cut_ready, cut_valid && $stable(cut_length) && $stable(total_profit) && $stable(last_cut), "cut word dropped or changed while stalled")
	`RCPC_ASSERT_IMPL(a_cut_range, clk, arst_n, cut_valid, cut_length != '0 && int'(cut_length) <= rcpc_pkg::MAX_LEN, "cut length out of range")
	`RCPC_ASSERT_IMPL(a_profit_same, clk, arst_n, acc && mid_q, total_profit == profit_q, "total profit changed within one cutting")
	`RCPC_ASSERT_IMPL(a_len_sum, clk, arst_n, acc, (int'(sum_q) + int'(cut_length)) <= rcpc_pkg::MAX_LEN, "pieces of one cutting exceed the rod")
endmodule

bind rod_cutting_profit_and_cuts_top rcpc_checker u_rcpc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cut_valid    (cut.valid),
	.cut_ready    (cut.ready),
	.cut_length   (cut.cut_length),
	.total_profit (cut.total_profit),
	.last_cut     (cut.last_cut)
);

>>> tb/sv/tb.sv
// Self-checking bench for the rod cutting block: price loads in, best cutting words out.
`timescale 1ns / 100ps

module tb;
	import rcpc_pkg::*;

	localparam int LIMIT = 400000;   // cycles before the run is declared hung
	localparam int SETTLE = 10;      // quiet cycles after the last cut word
	localparam int TOTAL_WORDS = 370;   // random phases start until this many price words are sent

	// one cut word as it leaves the block
	typedef struct packed {
		logic [CUTF_W-1:0]   len;
		logic [PROFIT_W-1:0] profit;
		logic                last;
	} cut_word_t;

	// one row of the directed table: optional rod length write, then one price word;
	// where typed is set the expected cutting is a single piece given in the row
	typedef struct packed {
		bit                  wr;
		logic [CFG_W-1:0]    rod;
		logic [PRICE_W-1:0]  price;
		bit                  typed;
		logic [CUTF_W-1:0]   t_len;
		logic [PROFIT_W-1:0] t_profit;
	} step_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	rcpc_price_if price_ch();
	rcpc_cut_if   cut_ch();

	rod_cutting_profit_and_cuts_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.price     (price_ch),
		.cut       (cut_ch)
	);

	always #6 clk = ~clk;

	// ---- predictor state: its own copy of the rod length and the price table ----
	logic [CFG_W-1:0]   rod_reg;
	logic [PRICE_W-1:0] price_tab [MAX_LEN];
	int                 loaded;
	int                 best_pf [MAX_LEN+1];
	int                 best_at [MAX_LEN+1];

	cut_word_t cuts_due[$];     // cut words still owed by the block, oldest first
	cut_word_t fresh_cuts[$];   // cutting worked out for the word just taken
	cut_word_t want;
	step_row_t steps[$];

	int bad_words = 0;
	int words_sent = 0;
	int cycles = 0;
	int tx_quiet = 0;
	int rx_quiet = 0;
	int rx_hold = 0;
	int rx_roll;

	function automatic step_row_t mk_row(bit wr, int rod, int price, bit typed,
		int t_len, int t_profit);
		step_row_t r;
		r.wr = wr;
		r.rod = CFG_W'(rod);
		r.price = PRICE_W'(price);
		r.typed = typed;
		r.t_len = CUTF_W'(t_len);
		r.t_profit = PROFIT_W'(t_profit);
		return r;
	endfunction

	// Takes one price word into the table; when the load is complete, runs the
	// bottom-up solve and walks back from the full length into fresh_cuts.
	task automatic take_price(input logic [PRICE_W-1:0] p);
		int eff, n, i, cand, best, at, remain, c;
		fresh_cuts.delete();
		// zero length counts as one, anything past the table saturates
		eff = (rod_reg == '0) ? 1 : ((int'(rod_reg) > MAX_LEN) ? MAX_LEN : int'(rod_reg));
		if (loaded < MAX_LEN)
			price_tab[loaded] = p;
		loaded++;
		if (loaded < eff)
			return;
		loaded = 0;

		best_pf[0] = 0;
		best_at[0] = 0;
		for (n = 1; n <= eff; n++) begin
			best = 0;
			at = n;   // no gain: the length stays one uncut piece
			for (i = 1; i <= n; i++) begin
				cand = int'(price_tab[i-1]) + best_pf[n-i];
				if (cand > int'(PROFIT_MAX))
					cand = int'(PROFIT_MAX);
				// only a strict rise moves the cut, so the shortest piece wins ties
				if (best < cand) begin
					best = cand;
					at = i;
				end
			end
			best_pf[n] = best;
			best_at[n] = at;
		end

		remain = eff;
		while (remain > 0) begin
			c = best_at[remain];
			if (c == 0 || c > remain)
				c = remain;
			remain -= c;
			fresh_cuts.push_back('{len: CUTF_W'(c), profit: PROFIT_W'(best_pf[eff]),
				last: (remain == 0)});
		end
	endtask

	// Offers one price word after a random gap and waits for the handshake.
	task automatic send_price(input logic [PRICE_W-1:0] p, input bit typed,
		input logic [CUTF_W-1:0] t_len, input logic [PROFIT_W-1:0] t_profit);
		int gap, roll;
		if (tx_quiet > 0) begin
			tx_quiet--;
			gap = 0;
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 4) begin
				tx_quiet = $urandom_range(20, 60);   // a burst with no gaps
				gap = 0;
			end else if (roll < 55) begin
				gap = 0;
			end else if (roll < 92) begin
				gap = $urandom_range(1, 3);
			end else begin
				gap = $urandom_range(8, 30);
			end
		end

		@(negedge clk);
		if (gap > 0) begin
			price_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		price_ch.valid <= 1'b1;
		price_ch.price_value <= p;
		do @(posedge clk); while (price_ch.ready !== 1'b1);

		// word taken at this edge
		words_sent++;
		take_price(p);
		if (typed)
			cuts_due.push_back('{len: t_len, profit: t_profit, last: 1'b1});
		else
			foreach (fresh_cuts[j]) cuts_due.push_back(fresh_cuts[j]);
	endtask

	// Drops valid and holds off until every owed cut word is in, then lets the
	// block wind down.
	task automatic settle();
		@(negedge clk);
		price_ch.valid <= 1'b0;
		while (cuts_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Rod length write, only once the block has gone quiet; restarts the load.
	task automatic write_rod(input logic [CFG_W-1:0] v);
		settle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		rod_reg = v;
		loaded = 0;
	endtask

	// ---- cut side: random back-pressure, mostly short stalls, a few long ones ----
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			rx_hold--;
			cut_ch.ready <= 1'b0;
		end else if (rx_quiet > 0) begin
			rx_quiet--;
			cut_ch.ready <= 1'b1;
		end else begin
			rx_roll = $urandom_range(0, 99);
			if (rx_roll < 3) begin
				rx_quiet = $urandom_range(20, 80);
				cut_ch.ready <= 1'b1;
			end else if (rx_roll < 65) begin
				cut_ch.ready <= 1'b1;
			end else if (rx_roll < 95) begin
				rx_hold = $urandom_range(0, 2);
				cut_ch.ready <= 1'b0;
			end else begin
				rx_hold = $urandom_range(8, 40);
				cut_ch.ready <= 1'b0;
			end
		end
	end

	// ---- check each accepted cut word against the oldest owed one ----
	always @(posedge clk) begin
		if (arst_n && cut_ch.valid === 1'b1 && cut_ch.ready === 1'b1) begin
			if (cuts_due.size() == 0) begin
				bad_words++;
				if (bad_words <= 10)
					$display("%0t: stray cut word: len %0d profit %0d last %0b", $time,
						cut_ch.cut_length, cut_ch.total_profit, cut_ch.last_cut);
			end else begin
				want = cuts_due.pop_front();
				if (cut_ch.cut_length !== want.len || cut_ch.total_profit !== want.profit ||
					cut_ch.last_cut !== want.last) begin
					bad_words++;
					if (bad_words <= 10)
						$display("%0t: cut word wrong: exp %0d %0d %0b, got %0d %0d %0b",
							$time, want.len, want.profit, want.last,
							cut_ch.cut_length, cut_ch.total_profit, cut_ch.last_cut);
				end
			end
		end
	end

	// ---- hang guard ----
	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		int rod, eff, loads, style, upto, base, v, roll;
		logic [PRICE_W-1:0] p;

		price_ch.valid = 1'b0;
		price_ch.price_value = '0;
		cut_ch.ready = 1'b0;
		rod_reg = ROD_LEN_RESET;
		loaded = 0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part.
		// Reset length of 8 with the textbook price list: two pieces, 2 then 6.
		steps.push_back(mk_row(0, 0, 1, 0, 0, 0));
		steps.push_back(mk_row(0, 0, 5, 0, 0, 0));
		steps.push_back(mk_row(0, 0, 8, 0, 0, 0));
		steps.push_back(mk_row(0, 0, 9, 0, 0, 0));
		steps.push_back(mk_row(0, 0, 10, 0, 0, 0));
		steps.push_back(mk_row(0, 0, 17, 0, 0, 0));
		steps.push_back(mk_row(0, 0, 17, 0, 0, 0));
		steps.push_back(mk_row(0, 0, 20, 0, 0, 0));
		// Zero length reads as one: a single top-price piece.
		steps.push_back(mk_row(1, 0, 16'hFFFF, 1, 1, 16'hFFFF));
		// Length 3, one word in, then a write to length 2 throws the part-load away.
		steps.push_back(mk_row(1, 3, 7, 0, 0, 0));
		// All prices zero: no gain anywhere, so one uncut piece worth nothing.
		steps.push_back(mk_row(1, 2, 0, 0, 0, 0));
		steps.push_back(mk_row(0, 0, 0, 1, 2, 0));
		// Length 31 saturates to the full table; top prices give sixteen unit pieces.
		for (int k = 0; k < MAX_LEN; k++)
			steps.push_back(mk_row(k == 0, 31, 16'hFFFF, 0, 0, 0));

		foreach (steps[s]) begin
			if (steps[s].wr)
				write_rod(steps[s].rod);
			send_price(steps[s].price, steps[s].typed, steps[s].t_len, steps[s].t_profit);
		end

		// Random part: a rod length per phase, then whole loads with random content;
		// now and then a load is cut short and the next write restarts it.
		while (words_sent < TOTAL_WORDS) begin
			roll = $urandom_range(0, 99);
			if (roll < 8)
				rod = 0;
			else if (roll < 16)
				rod = $urandom_range(17, 31);
			else if (roll < 28)
				rod = MAX_LEN;
			else if (roll < 36)
				rod = 1;
			else if (roll < 60)
				rod = $urandom_range(2, 4);
			else
				rod = $urandom_range(5, 12);
			write_rod(CFG_W'(rod));
			eff = (rod == 0) ? 1 : ((rod > MAX_LEN) ? MAX_LEN : rod);

			loads = $urandom_range(1, 4);
			for (int ld = 0; ld < loads; ld++) begin
				style = $urandom_range(0, 4);
				base = $urandom_range(1, 4000);
				upto = eff;
				if (eff > 1 && $urandom_range(0, 19) == 0)
					upto = $urandom_range(1, eff - 1);   // broken load
				for (int k = 0; k < upto; k++) begin
					case (style)
						0: p = PRICE_W'($urandom_range(0, 65535));
						1: p = PRICE_W'($urandom_range(0, 15));   // small, many ties
						2: p = ($urandom_range(0, 3) == 0) ?
							PRICE_W'($urandom_range(0, 65535)) : '0;
						3: p = PRICE_W'($urandom_range(65520, 65535));
						default: begin
							// roughly proportional to length, so long and short pieces compete
							v = (k + 1) * base + $urandom_range(0, base / 2);
							p = (v > 65535) ? 16'hFFFF : PRICE_W'(v);
						end
					endcase
					send_price(p, 0, '0, '0);
				end
				if (upto < eff)
					break;
			end
		end

		settle();
		if (bad_words == 0 && cuts_due.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> sim.f
+incdir+src
src/rcpc_pkg.sv
src/rcpc_price_if.sv
src/rcpc_cut_if.sv
src/rcpc_ram.sv
src/rcpc_datapath.sv
src/rcpc_ctrl.sv
src/rod_cutting_profit_and_cuts_top.sv
src/rcpc_checker.sv
tb/sv/tb.sv
